// ===== src/jrk_pkg.sv =====
// ----------------------------------------------------------------------------
// jrk_pkg
// Shared widths, constants and types of the trajectory jerk accumulator.
// ----------------------------------------------------------------------------
package jrk_pkg;

   localparam int JOINT_COUNT_DEF = 6;
   localparam int MAX_JOINTS      = 6;

   localparam int TIME_W   = 32;
   localparam int VEL_W    = 32;
   localparam int SUM_W    = 48;
   localparam int STATUS_W = 2;

   // Serial multiplier operand and product widths.
   localparam int MUL_A_W = 55;
   localparam int MUL_B_W = 30;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Serial divider widths and the width of its iteration counter.
   localparam int DIV_N_W   = 74;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // Serial square root widths.
   localparam int ROOT_IN_W  = 64;
   localparam int ROOT_W     = ROOT_IN_W / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

   // Jerk terms are scaled down until they fit this many bits before squaring.
   localparam int SCALED_W = 30;
   localparam int SHIFT_W  = 5;

   localparam logic [MUL_B_W-1:0] US_PER_S = MUL_B_W'(1000000);
   localparam logic [SUM_W-1:0]   SUM_MAX  = {SUM_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_ZERO_STEP = 2'd2
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== src/jrk_mul.sv =====
// ----------------------------------------------------------------------------
// jrk_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module jrk_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jrk_pkg::MUL_A_W-1:0]  a,
   input  logic [jrk_pkg::MUL_B_W-1:0]  b,
   output logic [jrk_pkg::MUL_P_W-1:0]  product,
   output jrk_pkg::unit_stat_type       stat
);

   logic                        busy_ff, busy_in;
   logic [jrk_pkg::MUL_P_W-1:0] a_sh_ff, a_sh_in;
   logic [jrk_pkg::MUL_B_W-1:0] b_sh_ff, b_sh_in;
   logic [jrk_pkg::MUL_P_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_sh_in = jrk_pkg::MUL_P_W'(a);
         b_sh_in = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // The multiplier finishes as soon as no set bits remain.
         if (b_sh_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_sh_ff[0]) begin
               acc_in = acc_ff + a_sh_ff;
            end
            a_sh_in = a_sh_ff << 1;
            b_sh_in = b_sh_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (b_sh_ff == '0);

endmodule

// ===== src/jrk_div.sv =====
// ----------------------------------------------------------------------------
// jrk_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jrk_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jrk_pkg::DIV_N_W-1:0]  num,
   input  logic [jrk_pkg::DIV_D_W-1:0]  den,
   output logic [jrk_pkg::DIV_N_W-1:0]  quot,
   output jrk_pkg::unit_stat_type       stat
);

   logic                          busy_ff, busy_in;
   logic [jrk_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [jrk_pkg::DIV_N_W-1:0]   num_sh_ff, num_sh_in;
   logic [jrk_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [jrk_pkg::DIV_D_W-1:0]   den_ff, den_in;
   logic [jrk_pkg::DIV_D_W:0]     trial;
   logic                          fits;

   assign trial = {rem_ff, num_sh_ff[jrk_pkg::DIV_N_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      num_sh_in = num_sh_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = jrk_pkg::DIV_CNT_W'(jrk_pkg::DIV_N_W);
         num_sh_in = num;
         rem_in    = '0;
         den_in    = den;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            // Quotient bits enter at the bottom as the numerator leaves the top.
            cnt_in    = cnt_ff - 1'b1;
            num_sh_in = {num_sh_ff[jrk_pkg::DIV_N_W-2:0], fits};
            rem_in    = fits ? jrk_pkg::DIV_D_W'(trial - {1'b0, den_ff})
                             : trial[jrk_pkg::DIV_D_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      num_sh_ff <= num_sh_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   assign quot      = num_sh_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);

endmodule

// ===== src/jrk_sqrt.sv =====
// ----------------------------------------------------------------------------
// jrk_sqrt
// Integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module jrk_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jrk_pkg::ROOT_IN_W-1:0] radicand,
   output logic [jrk_pkg::ROOT_W-1:0]    root,
   output jrk_pkg::unit_stat_type        stat
);

   logic                           busy_ff, busy_in;
   logic [jrk_pkg::ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [jrk_pkg::ROOT_IN_W-1:0]  rad_sh_ff, rad_sh_in;
   logic [jrk_pkg::ROOT_W+1:0]     rem_ff, rem_in;
   logic [jrk_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [jrk_pkg::ROOT_W+1:0]     cur;
   logic [jrk_pkg::ROOT_W+1:0]     trial;
   logic                           fits;

   // The remainder stays below 2^32 until the final step.
   assign cur   = {rem_ff[jrk_pkg::ROOT_W-1:0],
                   rad_sh_ff[jrk_pkg::ROOT_IN_W-1:jrk_pkg::ROOT_IN_W-2]};
   assign trial = {root_ff, 2'b01};
   assign fits  = cur >= trial;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rad_sh_in = rad_sh_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = jrk_pkg::ROOT_CNT_W'(jrk_pkg::ROOT_W);
         rad_sh_in = radicand;
         rem_in    = '0;
         root_in   = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in    = cnt_ff - 1'b1;
            rad_sh_in = rad_sh_ff << 2;
            rem_in    = fits ? cur - trial : cur;
            root_in   = {root_ff[jrk_pkg::ROOT_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rad_sh_ff <= rad_sh_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);

endmodule

// ===== src/trajectory_jerk_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// trajectory_jerk_accumulator_top
// Sums finite-difference jerk norms over the points of one trajectory.
// ----------------------------------------------------------------------------
// One point is worked on at a time; req_stall is high from acceptance until
// the point is finished. A point that yields no jerk term goes from S_CHECK
// straight to S_UPDATE, and on a last point on to S_FINAL. An interior point
// takes, per joint, three multiply-divide passes (the shift-and-add
// multiplier, then the bit-serial divider), then the scaling, a square per
// joint and the square root; the serial divider takes most of that time. The
// last point of a trajectory delivers one transaction with the saturating sum
// (zero for a short trajectory) and a status; the next point may be accepted
// while it waits to be taken.
module trajectory_jerk_accumulator_top #(
   parameter int JOINT_COUNT = jrk_pkg::JOINT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [jrk_pkg::TIME_W-1:0]    req_timestamp_us,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_0,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_1,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_2,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_3,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_4,
   input  logic signed [jrk_pkg::VEL_W-1:0] req_joint_velocity_5,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [jrk_pkg::SUM_W-1:0]     rsp_total_jerk,
   output logic [jrk_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int TW     = jrk_pkg::TIME_W;
   localparam int VW     = jrk_pkg::VEL_W;
   localparam int SW     = jrk_pkg::SUM_W;
   localparam int ACC_W  = 54;
   localparam int NORM_W = jrk_pkg::ROOT_W + 18;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_CHECK  = 14'b00000000000010,
      S_MUL    = 14'b00000000000100,
      S_MUL_W  = 14'b00000000001000,
      S_DIV    = 14'b00000000010000,
      S_DIV_W  = 14'b00000000100000,
      S_SHIFT  = 14'b00000001000000,
      S_SQ     = 14'b00000010000000,
      S_SQ_W   = 14'b00000100000000,
      S_ROOT   = 14'b00001000000000,
      S_ROOT_W = 14'b00010000000000,
      S_SUM    = 14'b00100000000000,
      S_UPDATE = 14'b01000000000000,
      S_FINAL  = 14'b10000000000000
   } state_type;

   typedef enum logic [1:0] {
      PH_PREV = 2'd0,
      PH_NEXT = 2'd1,
      PH_JERK = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [JIDX_W-1:0] k_ff, k_in;

   logic [TW-1:0]        t_now_ff, t_now_in;
   logic signed [VW-1:0] v_now_ff [JOINT_COUNT];
   logic signed [VW-1:0] v_now_in [JOINT_COUNT];
   logic                 last_ff, last_in;
   logic signed [VW-1:0] ov_ff [JOINT_COUNT];
   logic signed [VW-1:0] ov_in [JOINT_COUNT];
   logic signed [VW-1:0] nv_ff [JOINT_COUNT];
   logic signed [VW-1:0] nv_in [JOINT_COUNT];
   logic [TW-1:0]        ot_ff, ot_in, nt_ff, nt_in;
   logic [1:0]           count_ff, count_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic                 zero_ff, zero_in;

   logic [TW-1:0] dt_mag_ff [3];
   logic [TW-1:0] dt_mag_in [3];
   logic [2:0]    dt_neg_ff, dt_neg_in;
   logic          dtz_ff, dtz_in;
   logic          sign_ff, sign_in;
   logic signed [ACC_W-1:0] ap_ff, ap_in, an_ff, an_in;
   logic [SW-1:0] j_ff [JOINT_COUNT];
   logic [SW-1:0] j_in [JOINT_COUNT];
   logic [SW-1:0] mx_ff, mx_in;
   logic [jrk_pkg::SHIFT_W-1:0] s_ff, s_in;
   logic [jrk_pkg::ROOT_IN_W-1:0] sq_ff, sq_in;
   logic [SW-1:0] norm_ff, norm_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_jerk_ff, rsp_jerk_in;
   jrk_pkg::status_type rsp_status_ff, rsp_status_in;

   logic signed [VW-1:0] req_vel [jrk_pkg::MAX_JOINTS];

   logic mul_start, div_start, root_start;
   logic [jrk_pkg::MUL_A_W-1:0] mul_a;
   logic [jrk_pkg::MUL_B_W-1:0] mul_b;
   logic [jrk_pkg::MUL_P_W-1:0] mul_p;
   logic [jrk_pkg::DIV_D_W-1:0] div_den;
   logic [jrk_pkg::DIV_N_W-1:0] div_q;
   logic [jrk_pkg::ROOT_W-1:0]  root_val;
   jrk_pkg::unit_stat_type mul_stat, div_stat, root_stat;

   logic req_accept;
   logic k_last;
   logic signed [VW:0] dvp, dvn, dv_sel;
   logic [VW:0] dv_mag;
   logic signed [jrk_pkg::MUL_A_W-1:0] da;
   logic [jrk_pkg::MUL_A_W-1:0] da_mag;
   logic [jrk_pkg::MUL_A_W-1:0] op_mag;
   logic op_neg;
   logic dt_neg_sel;
   logic [SW-1:0] c_full;
   logic [jrk_pkg::SCALED_W-1:0] c_val;
   logic [TW:0] dt_raw [3];
   logic [ACC_W-1:0] q_acc;
   logic [SW-1:0] jerk_val;
   logic [NORM_W-1:0] norm_wide;
   logic [SW:0] sum_wide;

   assign req_vel[0] = req_joint_velocity_0;
   assign req_vel[1] = req_joint_velocity_1;
   assign req_vel[2] = req_joint_velocity_2;
   assign req_vel[3] = req_joint_velocity_3;
   assign req_vel[4] = req_joint_velocity_4;
   assign req_vel[5] = req_joint_velocity_5;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign k_last     = (k_ff == JIDX_W'(JOINT_COUNT - 1));

   // Time steps between the two stored points and from each of them to the current one.
   assign dt_raw[0] = {1'b0, nt_ff} - {1'b0, ot_ff};
   assign dt_raw[1] = {1'b0, t_now_ff} - {1'b0, nt_ff};
   assign dt_raw[2] = {1'b0, t_now_ff} - {1'b0, ot_ff};

   assign dvp    = {nv_ff[k_ff][VW-1], nv_ff[k_ff]} - {ov_ff[k_ff][VW-1], ov_ff[k_ff]};
   assign dvn    = {v_now_ff[k_ff][VW-1], v_now_ff[k_ff]}
                 - {nv_ff[k_ff][VW-1], nv_ff[k_ff]};
   assign dv_sel = (phase_ff == PH_PREV) ? dvp : dvn;
   assign dv_mag = dv_sel[VW] ? (VW + 1)'(-dv_sel) : (VW + 1)'(dv_sel);
   assign da     = {an_ff[ACC_W-1], an_ff} - {ap_ff[ACC_W-1], ap_ff};
   assign da_mag = da[jrk_pkg::MUL_A_W-1] ? jrk_pkg::MUL_A_W'(-da)
                                          : jrk_pkg::MUL_A_W'(da);

   always_comb begin
      op_mag     = jrk_pkg::MUL_A_W'(dv_mag);
      op_neg     = dv_sel[VW];
      dt_neg_sel = dt_neg_ff[0];
      div_den    = dt_mag_ff[0];
      case (phase_ff)
         PH_NEXT: begin
            dt_neg_sel = dt_neg_ff[1];
            div_den    = dt_mag_ff[1];
         end
         PH_JERK: begin
            op_mag     = da_mag;
            op_neg     = da[jrk_pkg::MUL_A_W-1];
            dt_neg_sel = dt_neg_ff[2];
            div_den    = dt_mag_ff[2];
         end
         default: ;
      endcase
   end

   assign c_full    = j_ff[k_ff] >> s_ff;
   assign c_val     = c_full[jrk_pkg::SCALED_W-1:0];
   assign q_acc     = {1'b0, div_q[ACC_W-2:0]};
   assign jerk_val  = (|div_q[jrk_pkg::DIV_N_W-1:SW]) ? jrk_pkg::SUM_MAX : div_q[SW-1:0];
   assign norm_wide = NORM_W'(root_val) << s_ff;
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, norm_ff};

   assign mul_start  = (state_ff == S_MUL) || (state_ff == S_SQ);
   assign mul_a      = (state_ff == S_SQ) ? jrk_pkg::MUL_A_W'(c_val) : op_mag;
   assign mul_b      = (state_ff == S_SQ) ? c_val : jrk_pkg::US_PER_S;
   assign div_start  = (state_ff == S_DIV);
   assign root_start = (state_ff == S_ROOT);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      k_in          = k_ff;
      t_now_in      = t_now_ff;
      v_now_in      = v_now_ff;
      last_in       = last_ff;
      ov_in         = ov_ff;
      nv_in         = nv_ff;
      ot_in         = ot_ff;
      nt_in         = nt_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      zero_in       = zero_ff;
      dt_mag_in     = dt_mag_ff;
      dt_neg_in     = dt_neg_ff;
      dtz_in        = dtz_ff;
      sign_in       = sign_ff;
      ap_in         = ap_ff;
      an_in         = an_ff;
      j_in          = j_ff;
      mx_in         = mx_ff;
      s_in          = s_ff;
      sq_in         = sq_ff;
      norm_in       = norm_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_jerk_in   = rsp_jerk_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               t_now_in = req_timestamp_us;
               for (int i = 0; i < JOINT_COUNT; i++) begin
                  v_now_in[i] = req_vel[i];
               end
               last_in  = req_last_point;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            for (int i = 0; i < 3; i++) begin
               dt_neg_in[i] = dt_raw[i][TW];
               dt_mag_in[i] = dt_raw[i][TW] ? TW'(-dt_raw[i]) : dt_raw[i][TW-1:0];
            end
            dtz_in   = (dt_raw[0] == '0) || (dt_raw[1] == '0) || (dt_raw[2] == '0);
            k_in     = '0;
            phase_in = PH_PREV;
            mx_in    = '0;
            s_in     = '0;
            if (count_ff < 2'd2) begin
               state_in = S_UPDATE;
            end else if (dtz_in) begin
               norm_in  = jrk_pkg::SUM_MAX;
               state_in = S_SUM;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            sign_in  = op_neg ^ dt_neg_sel;
            state_in = S_MUL_W;
         end
         S_MUL_W: begin
            if (mul_stat.done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            state_in = S_DIV_W;
         end
         S_DIV_W: begin
            if (div_stat.done) begin
               case (phase_ff)
                  PH_PREV: begin
                     ap_in    = sign_ff ? -$signed(q_acc) : $signed(q_acc);
                     phase_in = PH_NEXT;
                     state_in = S_MUL;
                  end
                  PH_NEXT: begin
                     an_in    = sign_ff ? -$signed(q_acc) : $signed(q_acc);
                     phase_in = PH_JERK;
                     state_in = S_MUL;
                  end
                  default: begin
                     j_in[k_ff] = jerk_val;
                     if (jerk_val > mx_ff) begin
                        mx_in = jerk_val;
                     end
                     phase_in = PH_PREV;
                     if (k_last) begin
                        state_in = S_SHIFT;
                     end else begin
                        k_in     = JIDX_W'(k_ff + 1'b1);
                        state_in = S_MUL;
                     end
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // Scale all terms by the shift that brings the largest below 2^30.
            if (|mx_ff[SW-1:jrk_pkg::SCALED_W]) begin
               mx_in = mx_ff >> 1;
               s_in  = s_ff + 1'b1;
            end else begin
               k_in     = '0;
               sq_in    = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            state_in = S_SQ_W;
         end
         S_SQ_W: begin
            if (mul_stat.done) begin
               sq_in = sq_ff + mul_p[jrk_pkg::ROOT_IN_W-1:0];
               if (k_last) begin
                  state_in = S_ROOT;
               end else begin
                  k_in     = JIDX_W'(k_ff + 1'b1);
                  state_in = S_SQ;
               end
            end
         end
         S_ROOT: begin
            state_in = S_ROOT_W;
         end
         S_ROOT_W: begin
            if (root_stat.done) begin
               norm_in  = (|norm_wide[NORM_W-1:SW]) ? jrk_pkg::SUM_MAX
                                                    : norm_wide[SW-1:0];
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sum_in = sum_wide[SW] ? jrk_pkg::SUM_MAX : sum_wide[SW-1:0];
            if (dtz_ff) begin
               zero_in = 1'b1;
            end
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            ov_in    = nv_ff;
            nv_in    = v_now_ff;
            ot_in    = nt_ff;
            nt_in    = t_now_ff;
            if (count_ff != 2'd3) begin
               count_in = count_ff + 1'b1;
            end
            state_in = last_ff ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            // Wait until the output register is free, then start a new trajectory.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (count_ff != 2'd3) begin
                  rsp_jerk_in   = '0;
                  rsp_status_in = jrk_pkg::STATUS_SHORT;
               end else begin
                  rsp_jerk_in   = sum_ff;
                  rsp_status_in = zero_ff ? jrk_pkg::STATUS_ZERO_STEP : jrk_pkg::STATUS_OK;
               end
               for (int i = 0; i < JOINT_COUNT; i++) begin
                  ov_in[i] = '0;
                  nv_in[i] = '0;
               end
               ot_in    = '0;
               nt_in    = '0;
               count_in = '0;
               sum_in   = '0;
               zero_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         zero_ff      <= 1'b0;
         ot_ff        <= '0;
         nt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            ov_ff[i] <= '0;
            nv_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         zero_ff      <= zero_in;
         ot_ff        <= ot_in;
         nt_ff        <= nt_in;
         rsp_valid_ff <= rsp_valid_in;
         ov_ff        <= ov_in;
         nv_ff        <= nv_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      k_ff          <= k_in;
      t_now_ff      <= t_now_in;
      v_now_ff      <= v_now_in;
      last_ff       <= last_in;
      dt_mag_ff     <= dt_mag_in;
      dt_neg_ff     <= dt_neg_in;
      dtz_ff        <= dtz_in;
      sign_ff       <= sign_in;
      ap_ff         <= ap_in;
      an_ff         <= an_in;
      j_ff          <= j_in;
      mx_ff         <= mx_in;
      s_ff          <= s_in;
      sq_ff         <= sq_in;
      norm_ff       <= norm_in;
      rsp_jerk_ff   <= rsp_jerk_in;
      rsp_status_ff <= rsp_status_in;
   end

   jrk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p),
      .stat    (mul_stat)
   );

   jrk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_p[jrk_pkg::DIV_N_W-1:0]),
      .den   (div_den),
      .quot  (div_q),
      .stat  (div_stat)
   );

   jrk_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_ff),
      .root     (root_val),
      .stat     (root_stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_jerk = rsp_jerk_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   // A zero time step always leaves the running sum saturated.
   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      zero_ff |-> (sum_ff == jrk_pkg::SUM_MAX))
      else $error("zero time step seen but sum not saturated");

   // The running sum only grows until the trajectory ends.
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINAL) |=> (sum_ff >= $past(sum_ff)))
      else $error("running jerk sum decreased");

   // A short trajectory reports a zero sum.
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == jrk_pkg::STATUS_SHORT)) |-> (rsp_total_jerk == '0))
      else $error("short trajectory with nonzero sum");

   // An accepted point is never followed by a second one in the next cycle.
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("point accepted while previous one in progress");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives whole trajectories into the jerk accumulator, predicts each
// trajectory's summed jerk norm and status, and checks every response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  JOINTS       = jrk_pkg::JOINT_COUNT_DEF;
   localparam int  IDLE_LIMIT   = 20000;
   localparam int  DRAIN_CYCLES = 2500;
   localparam int  TARGET_ITEMS = 2000;
   localparam bit [63:0] SAT    = 64'hFFFF_FFFF_FFFF;
   localparam bit [63:0] USEC   = 64'd1000000;

   typedef struct packed {
      bit [31:0]      ts;
      bit [5:0][31:0] vel;
      bit             last;
   } point_type;

   typedef struct packed {
      bit [jrk_pkg::SUM_W-1:0] total;
      jrk_pkg::status_type     status;
   } summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_timestamp_us = '0;
   logic signed [31:0] req_joint_velocity_0 = '0, req_joint_velocity_1 = '0;
   logic signed [31:0] req_joint_velocity_2 = '0, req_joint_velocity_3 = '0;
   logic signed [31:0] req_joint_velocity_4 = '0, req_joint_velocity_5 = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [jrk_pkg::SUM_W-1:0] rsp_total_jerk;
   logic [jrk_pkg::STATUS_W-1:0] rsp_status;

   trajectory_jerk_accumulator_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_type   pending_points[$];
   summary_type expected_summaries[$];
   int          errors = 0;
   bit          req_taken = 1'b0;
   bit          stimulus_done = 1'b0;

   // Predictor state, one trajectory at a time.
   longint      hist_old_vel[6], hist_new_vel[6];
   bit [31:0]   hist_old_ts, hist_new_ts;
   int          seen_points;
   bit [63:0]   running_sum;
   bit          zero_step_flag;

   function automatic bit [63:0] magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res = 0;
      bit [63:0] bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x -= res + bt;
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic longint accel_of(longint dv, longint dt);
      bit [63:0] m = magnitude(dv) * USEC / magnitude(dt);
      bit neg = (dv < 0) != (dt < 0);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic bit [63:0] jerk_of(longint da, longint dt);
      bit [63:0] a = magnitude(da);
      bit [63:0] d = magnitude(dt);
      bit [63:0] q = a / d;
      bit [63:0] r = a % d;
      bit [63:0] j;
      if (q > SAT / USEC) return SAT;
      j = q * USEC + r * USEC / d;
      return j > SAT ? SAT : j;
   endfunction

   function automatic void clear_history();
      for (int k = 0; k < 6; k++) begin
         hist_old_vel[k] = 0;
         hist_new_vel[k] = 0;
      end
      hist_old_ts = 0;
      hist_new_ts = 0;
      seen_points = 0;
      running_sum = 0;
      zero_step_flag = 0;
   endfunction

   function automatic bit [63:0] norm_of(point_type p, longint vnow[6]);
      longint dt1 = longint'(hist_new_ts) - longint'(hist_old_ts);
      longint dt2 = longint'(p.ts) - longint'(hist_new_ts);
      longint dt3 = longint'(p.ts) - longint'(hist_old_ts);
      bit [63:0] j[6];
      bit [63:0] mx = 0, sq = 0, n, c;
      int s = 0;
      longint ap, an;
      if (dt1 == 0 || dt2 == 0 || dt3 == 0) begin
         zero_step_flag = 1;
         return SAT;
      end
      for (int k = 0; k < JOINTS; k++) begin
         ap = accel_of(hist_new_vel[k] - hist_old_vel[k], dt1);
         an = accel_of(vnow[k] - hist_new_vel[k], dt2);
         j[k] = jerk_of(an - ap, dt3);
         if (j[k] > mx) mx = j[k];
      end
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int k = 0; k < JOINTS; k++) begin
         c = j[k] >> s;
         sq += c * c;
      end
      n = int_sqrt(sq) << s;
      return n > SAT ? SAT : n;
   endfunction

   function automatic void predict_point(point_type p);
      longint vnow[6];
      summary_type e;
      for (int k = 0; k < 6; k++) vnow[k] = longint'($signed(p.vel[k]));
      if (seen_points >= 2) begin
         running_sum += norm_of(p, vnow);
         if (running_sum > SAT) running_sum = SAT;
      end
      for (int k = 0; k < 6; k++) begin
         hist_old_vel[k] = hist_new_vel[k];
         hist_new_vel[k] = vnow[k];
      end
      hist_old_ts = hist_new_ts;
      hist_new_ts = p.ts;
      if (seen_points < 3) seen_points++;
      if (p.last) begin
         if (seen_points < 3) begin
            e.total = '0;
            e.status = jrk_pkg::STATUS_SHORT;
         end else begin
            e.total = running_sum[jrk_pkg::SUM_W-1:0];
            e.status = zero_step_flag ? jrk_pkg::STATUS_ZERO_STEP : jrk_pkg::STATUS_OK;
         end
         expected_summaries = {expected_summaries, e};
         clear_history();
      end
   endfunction

   task automatic add_point(bit [31:0] ts, bit [5:0][31:0] vel, bit last);
      point_type p;
      p.ts = ts;
      p.vel = vel;
      p.last = last;
      pending_points = {pending_points, p};
   endtask

   function automatic bit [31:0] rand_velocity();
      int mode = $urandom_range(0, 9);
      if (mode < 5) return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
      if (mode < 8) return $urandom();
      return mode == 8 ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   task automatic add_trajectory(int len);
      bit [31:0] ts = $urandom_range(0, 1000000);
      bit [5:0][31:0] vel;
      int r;
      for (int i = 0; i < len; i++) begin
         for (int k = 0; k < 6; k++) vel[k] = rand_velocity();
         add_point(ts, vel, i == len - 1);
         r = $urandom_range(0, 99);
         if (r < 4) ts = ts;                       // repeated timestamp
         else if (r < 9) ts = $urandom();          // arbitrary jump, may go back
         else if (r < 14) ts = ts + $urandom_range(1, 5);
         else ts = ts + $urandom_range(1, 200000);
      end
   endtask

   // Stimulus: directed trajectories, then random ones.
   initial begin
      bit [5:0][31:0] v;
      int n;
      clear_history();
      v = '0;
      add_point(32'd0, v, 1'b1);                   // single point
      add_point(32'd0, v, 1'b0);
      add_point(32'd1000, v, 1'b1);                // two points
      for (int k = 0; k < 6; k++) v[k] = 32'h0001_0000;
      add_point(32'd0, v, 1'b0);
      for (int k = 0; k < 6; k++) v[k] = 32'h0002_0000;
      add_point(32'd1000, v, 1'b0);
      for (int k = 0; k < 6; k++) v[k] = 32'h0000_8000;
      add_point(32'd3000, v, 1'b1);                // plain three points
      for (int k = 0; k < 6; k++) v[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      add_point(32'd0, v, 1'b0);
      for (int k = 0; k < 6; k++) v[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      add_point(32'd1, v, 1'b0);
      for (int k = 0; k < 6; k++) v[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      add_point(32'd2, v, 1'b0);                   // extreme, saturating sum
      add_point(32'd3, '0, 1'b1);
      add_point(32'd500, v, 1'b0);
      add_point(32'd500, '0, 1'b0);                // zero time step
      add_point(32'd900, v, 1'b1);
      add_point(32'hFFFF_FFFF, v, 1'b0);           // decreasing timestamps
      add_point(32'hFFFF_0000, '0, 1'b0);
      add_point(32'd0, v, 1'b0);
      add_point(32'd0, '1, 1'b1);                  // zero step on last point
      add_point(32'd10, '1, 1'b0);
      add_point(32'd20, '0, 1'b0);
      add_point(32'd40, '1, 1'b0);
      add_point(32'd50, '0, 1'b1);
      n = pending_points.size();
      while (n < TARGET_ITEMS) begin
         int len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         add_trajectory(len);
         n += len;
      end
      stimulus_done = 1'b1;
   end

   // Request driver: bursts with random gaps.
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      point_type p;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0 || pending_points.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            p = pending_points.pop_front();
            req_valid <= 1'b1;
            req_timestamp_us <= p.ts;
            req_joint_velocity_0 <= p.vel[0];
            req_joint_velocity_1 <= p.vel[1];
            req_joint_velocity_2 <= p.vel[2];
            req_joint_velocity_3 <= p.vel[3];
            req_joint_velocity_4 <= p.vel[4];
            req_joint_velocity_5 <= p.vel[5];
            req_last_point <= p.last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Response stall: calm stretches and choppy stretches in random order.
   int stall_phase = 0;
   bit choppy = 1'b0;
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_phase <= $urandom_range(20, 3000);
         choppy <= $urandom_range(0, 1);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      rsp_stall <= choppy ? ($urandom_range(0, 2) != 0) : 1'b0;
   end

   // Monitor: predict on accepted points, check accepted responses.
   int idle_cycles = 0;
   always @(posedge clock) begin
      summary_type e;
      point_type p;
      bit act;
      bit took;
      act = 1'b0;
      took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            p.ts = req_timestamp_us;
            p.vel = {req_joint_velocity_5, req_joint_velocity_4, req_joint_velocity_3,
                     req_joint_velocity_2, req_joint_velocity_1, req_joint_velocity_0};
            p.last = req_last_point;
            predict_point(p);
            took = 1'b1;
            act = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            act = 1'b1;
            if (expected_summaries.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction total_jerk=%0h status=%0d",
                        $time, rsp_total_jerk, rsp_status);
            end else begin
               e = expected_summaries.pop_front();
               if (rsp_total_jerk !== e.total) begin
                  errors++;
                  $display("%0t: total_jerk expected %0h actual %0h",
                           $time, e.total, rsp_total_jerk);
               end
               if (rsp_status !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, e.status, rsp_status);
               end
            end
         end
         if (act) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
      req_taken <= took;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      while (pending_points.size() != 0 || req_valid || expected_summaries.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_summaries.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
